// ----- rtl/core/tnp_pkg.sv -----
package tnp_pkg;

    localparam logic [7:0] T_IAC  = 8'd255;
    localparam logic [7:0] T_DONT = 8'd254;
    localparam logic [7:0] T_DO   = 8'd253;
    localparam logic [7:0] T_WONT = 8'd252;
    localparam logic [7:0] T_WILL = 8'd251;
    localparam logic [7:0] T_SB   = 8'd250;
    localparam logic [7:0] T_SE   = 8'd240;
    localparam logic [7:0] T_IP   = 8'd244;
    localparam logic [7:0] T_ESC  = 8'h1b;
    localparam logic [7:0] T_DEL  = 8'h7f;
    localparam logic [7:0] T_ETX  = 8'h03;
    localparam logic [7:0] T_NUL  = 8'h00;
    localparam logic [7:0] T_BS   = 8'h08;
    localparam logic [7:0] T_TAB  = 8'h09;
    localparam logic [7:0] T_LF   = 8'h0a;
    localparam logic [7:0] T_CR   = 8'h0d;
    localparam logic [7:0] T_SP   = 8'h20;
    localparam logic [7:0] T_CARET = 8'h5e;
    localparam logic [7:0] T_CHR_C = 8'h43;
    localparam logic [7:0] OPT_ECHO = 8'd1;

    localparam logic [2:0] PS_DATA   = 3'd0;
    localparam logic [2:0] PS_IAC    = 3'd1;
    localparam logic [2:0] PS_OPTION = 3'd2;
    localparam logic [2:0] PS_SUB    = 3'd3;
    localparam logic [2:0] PS_SUBIAC = 3'd4;

    localparam logic [1:0] CMD_WILL = 2'd0;
    localparam logic [1:0] CMD_DO   = 2'd2;

    localparam logic JOB_DATA = 1'b0;
    localparam logic JOB_NEG  = 1'b1;

    localparam logic [2:0] ECH_NONE  = 3'd0;
    localparam logic [2:0] ECH_LINE  = 3'd1;
    localparam logic [2:0] ECH_ERASE = 3'd2;
    localparam logic [2:0] ECH_INTR  = 3'd3;
    localparam logic [2:0] ECH_PRINT = 3'd4;

    localparam logic DEST_HOST = 1'b0;
    localparam logic DEST_LINK = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       kind;
        logic [2:0] echo_cls;
        logic [7:0] verb;
        logic [7:0] data;
        logic       line_end;
    } job_t;

    typedef struct packed {
        logic       dest;
        logic [7:0] out_byte;
        logic       line_end;
        logic       last;
    } word_t;

    function automatic logic [2:0] echo_len(input logic [2:0] cls, input logic [7:0] b);
        logic [2:0] len;
        begin
            case (cls)
                ECH_LINE:  len = 3'd2;
                ECH_ERASE: len = 3'd3;
                ECH_INTR:  len = 3'd4;
                ECH_PRINT: len = (b == T_IAC) ? 3'd2 : 3'd1;
                default:   len = 3'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [7:0] echo_byte(input logic [2:0] cls, input logic [2:0] idx,
                                             input logic [7:0] b);
        logic [7:0] r;
        begin
            r = b;
            case (cls)
                ECH_LINE:  r = (idx == 3'd0) ? T_CR : T_LF;
                ECH_ERASE: r = (idx == 3'd1) ? T_SP : T_BS;
                ECH_INTR: begin
                    case (idx)
                        3'd0:    r = T_CARET;
                        3'd1:    r = T_CHR_C;
                        3'd2:    r = T_CR;
                        default: r = T_LF;
                    endcase
                end
                default:   r = b;
            endcase
            return r;
        end
    endfunction

    function automatic word_t job_word(input job_t job, input logic [2:0] idx);
        word_t      w;
        logic [2:0] elen;
        begin
            elen = echo_len(job.echo_cls, job.data);
            w.dest = DEST_LINK;
            w.line_end = 1'b0;
            if (job.kind == JOB_NEG) begin
                case (idx)
                    3'd0:    w.out_byte = T_IAC;
                    3'd1:    w.out_byte = job.verb;
                    default: w.out_byte = job.data;
                endcase
                w.last = (idx == 3'd2);
            end else if (idx < elen) begin
                w.out_byte = echo_byte(job.echo_cls, idx, job.data);
                w.last = 1'b0;
            end else begin
                w.dest = DEST_HOST;
                w.out_byte = job.data;
                w.line_end = job.line_end;
                w.last = 1'b1;
            end
            return w;
        end
    endfunction

endpackage

// ----- rtl/core/tnp_front.sv -----
module tnp_front
    import tnp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic       echo_enable_reg;
    logic [2:0] parse_state_reg, parse_state_next;
    logic [1:0] pending_reg, pending_next;
    logic       after_cr_reg, after_cr_next;
    logic       esc_reg, esc_next;
    logic       accept;
    logic       push;
    logic       echo_req;
    logic [7:0] echo_in;
    logic [2:0] echo_cls;
    logic [7:0] verb_off;
    job_t       job;

    assign s_ready = !q_full;
    assign accept = s_valid && s_ready;
    assign verb_off = s_rx_byte - T_WILL;

    // Echo classification of the byte that goes to the host.
    always_comb begin
        echo_cls = ECH_NONE;
        esc_next = esc_reg;
        if (echo_req && echo_enable_reg) begin
            if (esc_reg) begin
                if (echo_in inside {[8'h40:8'h7e]}) begin
                    esc_next = 1'b0;
                end
            end else if (echo_in == T_ESC) begin
                esc_next = 1'b1;
            end else if (echo_in inside {T_CR, T_LF}) begin
                echo_cls = ECH_LINE;
            end else if (echo_in inside {T_BS, T_DEL}) begin
                echo_cls = ECH_ERASE;
            end else if (echo_in == T_ETX) begin
                echo_cls = ECH_INTR;
            end else if (echo_in >= T_SP || echo_in == T_TAB) begin
                echo_cls = ECH_PRINT;
            end
        end
    end

    always_comb begin
        parse_state_next = PS_DATA;
        pending_next = pending_reg;
        after_cr_next = after_cr_reg;
        push = 1'b0;
        echo_req = 1'b0;
        echo_in = s_rx_byte;
        job.kind = JOB_DATA;
        job.verb = T_WONT;
        job.data = s_rx_byte;
        job.line_end = 1'b0;
        case (parse_state_reg)
            PS_SUB: begin
                parse_state_next = (s_rx_byte == T_IAC) ? PS_SUBIAC : PS_SUB;
            end
            PS_SUBIAC: begin
                parse_state_next = (s_rx_byte == T_SE) ? PS_DATA : PS_SUB;
            end
            PS_OPTION: begin
                job.kind = JOB_NEG;
                if (pending_reg == CMD_DO) begin
                    push = 1'b1;
                    job.verb = (s_rx_byte == OPT_ECHO) ? T_WILL : T_WONT;
                end else if (pending_reg == CMD_WILL) begin
                    push = 1'b1;
                    job.verb = T_DONT;
                end
            end
            PS_IAC: begin
                if (s_rx_byte == T_IAC) begin
                    push = 1'b1;
                    echo_req = 1'b1;
                end else if (s_rx_byte inside {[T_WILL:T_DONT]}) begin
                    pending_next = verb_off[1:0];
                    parse_state_next = PS_OPTION;
                end else if (s_rx_byte == T_SB) begin
                    parse_state_next = PS_SUB;
                end else if (s_rx_byte == T_IP) begin
                    push = 1'b1;
                    echo_req = 1'b1;
                    echo_in = T_ETX;
                    job.data = T_ETX;
                end
            end
            default: begin
                if (s_rx_byte == T_IAC) begin
                    parse_state_next = PS_IAC;
                end else if (after_cr_reg && (s_rx_byte inside {T_NUL, T_LF})) begin
                    after_cr_next = 1'b0;
                end else begin
                    after_cr_next = (s_rx_byte == T_CR);
                    push = 1'b1;
                    echo_req = 1'b1;
                    job.line_end = (s_rx_byte inside {T_CR, T_LF});
                end
            end
        endcase
        job.echo_cls = (job.kind == JOB_DATA) ? echo_cls : ECH_NONE;
    end

    assign q_push = accept && push;
    assign q_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_enable_reg <= 1'b1;
            parse_state_reg <= PS_DATA;
            pending_reg <= CMD_WILL;
            after_cr_reg <= 1'b0;
            esc_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                echo_enable_reg <= cfg_wr_data;
            end
            if (accept) begin
                parse_state_reg <= parse_state_next;
                pending_reg <= pending_next;
                after_cr_reg <= after_cr_next;
                esc_reg <= esc_next;
            end
        end
    end

endmodule

// ----- rtl/core/tnp_queue.sv -----
module tnp_queue
    import tnp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/tnp_back.sv -----
module tnp_back
    import tnp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head_job,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_dest,
    output logic [7:0] m_out_byte,
    output logic       m_line_end,
    output logic       m_last
);

    logic [2:0] idx_reg;
    logic       m_valid_reg;
    word_t      word_reg;
    word_t      cur;
    logic       load;

    assign cur = job_word(head_job, idx_reg);
    assign load = !empty && (!m_valid_reg || m_ready);
    assign pop = load && cur.last;

    assign m_valid = m_valid_reg;
    assign m_dest = word_reg.dest;
    assign m_out_byte = word_reg.out_byte;
    assign m_line_end = word_reg.line_end;
    assign m_last = word_reg.last;

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg <= cur.last ? 3'd0 : idx_reg + 3'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/telnet_receive_parser_with_echo_top.sv -----
// A word's first result is registered in the output sequencer after its job has been
// written to the queue. Throughput: one result word per cycle while m_ready is high;
// a received word yields zero to five results, sent one job at a time.
// The four-entry job queue lets the parser accept words while results drain.
// Reset (synchronous, aresetn low) empties the queue, clears the parser to the
// data state and sets echo_enable to 1.
module telnet_receive_parser_with_echo_top
    import tnp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_dest,
    output logic [7:0] m_out_byte,
    output logic       m_line_end,
    output logic       m_last
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t push_job;
    job_t head_job;

    tnp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    tnp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    tnp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .empty      (q_empty),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_dest     (m_dest),
        .m_out_byte (m_out_byte),
        .m_line_end (m_line_end),
        .m_last     (m_last)
    );

endmodule

// ----- dv/tb.sv -----
module tb;
    import tnp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_ITEMS = 84;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_dest;
    logic [7:0] m_out_byte;
    logic       m_line_end;
    logic       m_last;

    int         idle_pct;
    int         stall_pct;
    logic       hold_req;
    int         hold_cnt;
    int         cycle_count;
    logic [7:0] rx_plan[$];

    class telnet_echo_scoreboard;
        word_t      reply_q[$];
        logic       echo_en;
        logic       after_cr;
        logic       in_escape;
        logic [2:0] parse_st;
        logic [1:0] verb_code;
        int         errors;

        function new();
            echo_en = 1'b1;
            after_cr = 1'b0;
            in_escape = 1'b0;
            parse_st = PS_DATA;
            verb_code = 2'd0;
            errors = 0;
        endfunction

        function void set_echo(logic v);
            echo_en = v;
        endfunction

        function int pending();
            return reply_q.size();
        endfunction

        function void push_word(logic dest, logic [7:0] b, logic le);
            word_t w;
            w.dest = dest;
            w.out_byte = b;
            w.line_end = le;
            w.last = 1'b0;
            reply_q.push_back(w);
        endfunction

        function void push_link(logic [7:0] b);
            push_word(DEST_LINK, b, 1'b0);
            if (b == T_IAC) begin
                push_word(DEST_LINK, b, 1'b0);
            end
        endfunction

        function void echo_rx(logic [7:0] b);
            if (!echo_en) begin
                return;
            end
            if (in_escape) begin
                if (b >= 8'h40 && b <= 8'h7e) begin
                    in_escape = 1'b0;
                end
                return;
            end
            if (b == T_ESC) begin
                in_escape = 1'b1;
            end else if (b == T_CR || b == T_LF) begin
                push_link(T_CR);
                push_link(T_LF);
            end else if (b == T_BS || b == T_DEL) begin
                push_link(T_BS);
                push_link(T_SP);
                push_link(T_BS);
            end else if (b == T_ETX) begin
                push_link(T_CARET);
                push_link(T_CHR_C);
                push_link(T_CR);
                push_link(T_LF);
            end else if (b >= T_SP || b == T_TAB) begin
                push_link(b);
            end
        endfunction

        function void note_rx(logic [7:0] b);
            int         base;
            logic [7:0] diff;
            word_t      w;
            base = reply_q.size();
            case (parse_st)
                PS_SUB: begin
                    if (b == T_IAC) begin
                        parse_st = PS_SUBIAC;
                    end
                end
                PS_SUBIAC: begin
                    parse_st = (b == T_SE) ? PS_DATA : PS_SUB;
                end
                PS_OPTION: begin
                    if (verb_code == CMD_DO) begin
                        push_word(DEST_LINK, T_IAC, 1'b0);
                        push_word(DEST_LINK, (b == OPT_ECHO) ? T_WILL : T_WONT, 1'b0);
                        push_word(DEST_LINK, b, 1'b0);
                    end else if (verb_code == CMD_WILL) begin
                        push_word(DEST_LINK, T_IAC, 1'b0);
                        push_word(DEST_LINK, T_DONT, 1'b0);
                        push_word(DEST_LINK, b, 1'b0);
                    end
                    parse_st = PS_DATA;
                end
                PS_IAC: begin
                    if (b == T_IAC) begin
                        parse_st = PS_DATA;
                        echo_rx(T_IAC);
                        push_word(DEST_HOST, T_IAC, 1'b0);
                    end else if (b >= T_WILL && b <= T_DONT) begin
                        diff = b - T_WILL;
                        verb_code = diff[1:0];
                        parse_st = PS_OPTION;
                    end else if (b == T_SB) begin
                        parse_st = PS_SUB;
                    end else begin
                        parse_st = PS_DATA;
                        if (b == T_IP) begin
                            echo_rx(T_ETX);
                            push_word(DEST_HOST, T_ETX, 1'b0);
                        end
                    end
                end
                default: begin
                    parse_st = PS_DATA;
                    if (b == T_IAC) begin
                        parse_st = PS_IAC;
                    end else if (after_cr && (b == T_NUL || b == T_LF)) begin
                        after_cr = 1'b0;
                    end else begin
                        after_cr = (b == T_CR);
                        echo_rx(b);
                        push_word(DEST_HOST, b, (b == T_CR || b == T_LF));
                    end
                end
            endcase
            if (reply_q.size() > base) begin
                w = reply_q.pop_back();
                w.last = 1'b1;
                reply_q.push_back(w);
            end
        endfunction

        function void check_out(word_t got);
            word_t want;
            if (reply_q.size() == 0) begin
                $error("Unexpected result: dest %0d out_byte %h line_end %0d last %0d",
                       got.dest, got.out_byte, got.line_end, got.last);
                errors++;
                return;
            end
            want = reply_q.pop_front();
            if (got.dest !== want.dest) begin
                $error("dest: expected %0d, actual %0d", want.dest, got.dest);
                errors++;
            end
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.line_end !== want.line_end) begin
                $error("line_end: expected %0d, actual %0d", want.line_end, got.line_end);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    telnet_echo_scoreboard sb;

    telnet_receive_parser_with_echo_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dest      (m_dest),
        .m_out_byte  (m_out_byte),
        .m_line_end  (m_line_end),
        .m_last      (m_last)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        word_t got;
        if (aresetn && m_valid && m_ready) begin
            got.dest = m_dest;
            got.out_byte = m_out_byte;
            got.line_end = m_line_end;
            got.last = m_last;
            sb.check_out(got);
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_cnt = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            m_ready <= 1'b0;
            hold_cnt--;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_rx(input logic [7:0] b);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_rx(b);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_echo(input logic v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_echo(v);
        @(negedge aclk);
    endtask

    task automatic send_plan(input bit pause_midway);
        int half;
        half = rx_plan.size() / 2;
        for (int i = 0; i < rx_plan.size(); i++) begin
            if (pause_midway && i == half) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            while ($urandom_range(99) < idle_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            send_rx(rx_plan[i]);
        end
        s_valid <= 1'b0;
        rx_plan.delete();
    endtask

    function automatic void plan_sequence();
        int kind;
        int n;
        kind = $urandom_range(15);
        case (kind)
            0, 1, 2, 3: rx_plan.push_back(8'($urandom_range(8'h20, 8'h7e)));
            4: rx_plan.push_back(8'($urandom_range(255)));
            5: rx_plan.push_back(8'($urandom_range(8'h1f)));
            6: begin
                rx_plan.push_back(T_CR);
                case ($urandom_range(2))
                    0: rx_plan.push_back(T_NUL);
                    1: rx_plan.push_back(T_LF);
                    default: rx_plan.push_back(8'($urandom_range(254)));
                endcase
            end
            7: begin
                case ($urandom_range(4))
                    0: rx_plan.push_back(T_LF);
                    1: rx_plan.push_back(T_BS);
                    2: rx_plan.push_back(T_DEL);
                    3: rx_plan.push_back(T_TAB);
                    default: rx_plan.push_back(T_ETX);
                endcase
            end
            8, 9: begin
                rx_plan.push_back(T_IAC);
                rx_plan.push_back(8'($urandom_range(T_WILL, T_DONT)));
                rx_plan.push_back($urandom_range(1) ? OPT_ECHO : 8'($urandom_range(255)));
            end
            10: begin
                rx_plan.push_back(T_IAC);
                rx_plan.push_back(T_SB);
                n = $urandom_range(1, 5);
                repeat (n) rx_plan.push_back(8'($urandom_range(254)));
                if ($urandom_range(3) == 0) begin
                    rx_plan.push_back(T_IAC);
                    rx_plan.push_back(8'($urandom_range(239)));
                    rx_plan.push_back(8'($urandom_range(254)));
                end
                rx_plan.push_back(T_IAC);
                rx_plan.push_back(T_SE);
            end
            11: begin
                rx_plan.push_back(T_IAC);
                rx_plan.push_back($urandom_range(1) ? T_IAC : T_IP);
            end
            12: begin
                rx_plan.push_back(T_IAC);
                rx_plan.push_back(8'($urandom_range(255)));
            end
            13: begin
                rx_plan.push_back(T_ESC);
                if ($urandom_range(3) != 0) begin
                    rx_plan.push_back(8'h5b);
                    n = $urandom_range(2);
                    repeat (n) rx_plan.push_back(8'($urandom_range(8'h30, 8'h39)));
                end
                rx_plan.push_back(8'($urandom_range(8'h40, 8'h7e)));
            end
            default: rx_plan.push_back(8'($urandom_range(8'h80, 8'hfe)));
        endcase
    endfunction

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        m_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        hold_cnt = 0;
        cycle_count = 0;
        idle_by_phase = '{0, 83, 0, 28};
        stall_by_phase = '{0, 0, 83, 28};
        sb = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        rx_plan = '{T_IAC, T_DO, OPT_ECHO,
                    T_IAC, T_WILL, T_IAC,
                    T_IAC, T_SB, OPT_ECHO, T_IAC, T_NUL, T_IAC, T_SE,
                    T_IAC, T_IAC,
                    T_IAC, T_IP,
                    T_IAC, 8'hf1,
                    T_CR, T_NUL, T_CR, T_LF,
                    T_BS, T_ETX,
                    T_ESC, 8'h5b, 8'h41};
        send_plan(1'b0);

        for (int p = 0; p < 4; p++) begin
            write_echo(p[0]);
            idle_pct = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            while (rx_plan.size() < PHASE_ITEMS) begin
                plan_sequence();
            end
            if (p == 0) begin
                hold_req = 1'b1;
            end
            send_plan(p == 1);
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/tnp_pkg.sv
rtl/core/tnp_front.sv
rtl/core/tnp_queue.sv
rtl/core/tnp_back.sv
rtl/core/telnet_receive_parser_with_echo_top.sv
dv/tb.sv
